// ===== hw/rtl/hcbd_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types and constants for the HTTP chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

    localparam int unsigned DEF_MAX_BODY_BYTES  = 1048576;
    localparam int unsigned DEF_CHUNK_SIZE_BITS = 32;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned LEN_W      = 21;
    localparam int unsigned IN_TDATA_W = 8;
    localparam int unsigned OUT_DATA_W = 32;

    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned QPTR_W  = $clog2(Q_DEPTH);

    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic              has_data;
        logic [BYTE_W-1:0] data_byte;
        logic              has_sum;
        logic [LEN_W-1:0]  length;
    } t_entry;

endpackage

// ===== hw/rtl/hcbd_front.sv =====
// ----------------------------------------------------------------------------
// hcbd_front
// Chunk framing parser. Classifies each accepted byte and queues the data
// byte and end-of-body summary that it produces.
// ----------------------------------------------------------------------------
module hcbd_front #(
    parameter int unsigned MAX_BODY_BYTES  = hcbd_pkg::DEF_MAX_BODY_BYTES,
    parameter int unsigned CHUNK_SIZE_BITS = hcbd_pkg::DEF_CHUNK_SIZE_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [hcbd_pkg::BYTE_W-1:0] i_byte,
    input  logic                        i_final,
    output logic                        o_push,
    output hcbd_pkg::t_entry            o_entry
);
    import hcbd_pkg::*;

    localparam logic [2:0] PH_SIZE_FIRST = 3'd0;
    localparam logic [2:0] PH_SIZE       = 3'd1;
    localparam logic [2:0] PH_EXT        = 3'd2;
    localparam logic [2:0] PH_EXT_CR     = 3'd3;
    localparam logic [2:0] PH_DATA       = 3'd4;
    localparam logic [2:0] PH_AFTER_DATA = 3'd5;
    localparam logic [2:0] PH_AFTER_CR   = 3'd6;
    localparam logic [2:0] PH_DONE       = 3'd7;

    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

    localparam int unsigned CW        = CHUNK_SIZE_BITS;
    localparam int unsigned LEN_LIMIT = (1 << LEN_W) - 1;
    localparam int unsigned CAP_INT   = (MAX_BODY_BYTES < LEN_LIMIT) ? MAX_BODY_BYTES
                                                                     : LEN_LIMIT;
    localparam logic [LEN_W-1:0] COUNT_CAP = LEN_W'(CAP_INT);

    logic [2:0]        r_phase, n_phase;
    logic [CW-1:0]     r_chunk, n_chunk;
    logic [LEN_W-1:0]  r_count, n_count;

    logic [BYTE_W-1:0] w_lower;
    logic              w_is_hex;
    logic [3:0]        w_digit;
    logic [CW-1:0]     w_size_next;
    logic              w_chunk_zero;
    logic              w_has_data;
    logic [LEN_W-1:0]  w_count_step;

    always_comb begin
        w_lower  = i_byte | 8'h20;
        w_is_hex = 1'b0;
        w_digit  = 4'd0;
        if (i_byte inside {[8'h30:8'h39]}) begin
            w_is_hex = 1'b1;
            w_digit  = 4'(i_byte - 8'h30);
        end else if (w_lower inside {[8'h61:8'h66]}) begin
            w_is_hex = 1'b1;
            w_digit  = 4'(w_lower - 8'h57);
        end
    end

    // Shifting in a digit overflows exactly when the top nibble is nonzero.
    assign w_size_next  = (r_chunk[CW-1 -: 4] != 4'd0) ? {CW{1'b1}}
                                                        : {r_chunk[CW-5:0], w_digit};
    assign w_chunk_zero = (r_chunk == '0);

    always_comb begin
        n_phase    = r_phase;
        n_chunk    = r_chunk;
        w_has_data = 1'b0;
        case (r_phase)
            PH_SIZE_FIRST: begin
                if (w_is_hex) begin
                    n_chunk = CW'(w_digit);
                    n_phase = PH_SIZE;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_SIZE: begin
                if (w_is_hex) begin
                    n_chunk = w_size_next;
                end else if (w_chunk_zero) begin
                    n_phase = PH_DONE;
                end else begin
                    n_phase = (i_byte == CH_CR) ? PH_EXT_CR : PH_EXT;
                end
            end
            PH_EXT: begin
                if (i_byte == CH_CR) begin
                    n_phase = PH_EXT_CR;
                end
            end
            PH_EXT_CR: begin
                if (i_byte == CH_LF) begin
                    n_phase = w_chunk_zero ? PH_DONE : PH_DATA;
                end else if (i_byte != CH_CR) begin
                    n_phase = PH_EXT;
                end
            end
            PH_DATA: begin
                if (w_chunk_zero) begin
                    n_phase = PH_AFTER_DATA;
                end else begin
                    w_has_data = 1'b1;
                    n_chunk    = r_chunk - CW'(1);
                    if (r_chunk == CW'(1)) begin
                        n_phase = PH_AFTER_DATA;
                    end
                end
            end
            PH_AFTER_DATA: begin
                if (i_byte == CH_CR) begin
                    n_phase = PH_AFTER_CR;
                end else if (w_is_hex) begin
                    n_chunk = CW'(w_digit);
                    n_phase = PH_SIZE;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_AFTER_CR: begin
                n_phase = (i_byte == CH_LF) ? PH_SIZE_FIRST : PH_DONE;
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase

        w_count_step = r_count;
        if (w_has_data && (r_count < COUNT_CAP)) begin
            w_count_step = r_count + LEN_W'(1);
        end
        n_count = w_count_step;

        if (i_final) begin
            n_phase = PH_SIZE_FIRST;
            n_chunk = '0;
            n_count = '0;
        end
    end

    always_comb begin
        o_entry.has_data  = w_has_data;
        o_entry.data_byte = i_byte;
        o_entry.has_sum   = i_final;
        o_entry.length    = w_count_step;
        o_push            = i_accept && (w_has_data || i_final);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIZE_FIRST;
            r_chunk <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_chunk <= n_chunk;
            r_count <= n_count;
        end
    end

endmodule

// ===== hw/rtl/hcbd_queue.sv =====
// ----------------------------------------------------------------------------
// hcbd_queue
// Small FIFO of parsed entries between the parser and the result stage.
// ----------------------------------------------------------------------------
module hcbd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  hcbd_pkg::t_entry i_entry,
    input  logic             i_pop,
    output hcbd_pkg::t_entry o_head,
    output logic             o_empty,
    output logic             o_full
);
    import hcbd_pkg::*;

    t_entry            r_mem [Q_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    logic w_do_push;
    logic w_do_pop;

    assign o_empty   = (r_count == '0);
    assign o_full    = (r_count == (QPTR_W + 1)'(Q_DEPTH));
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_head    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + (QPTR_W + 1)'(1);
                2'b01:   r_count <= r_count - (QPTR_W + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hw/rtl/hcbd_back.sv =====
// ----------------------------------------------------------------------------
// hcbd_back
// Result stage. Turns queued entries into output beats, the data byte first
// and the summary after it, through a registered output stage.
// ----------------------------------------------------------------------------
module hcbd_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  hcbd_pkg::t_entry                i_head,
    input  logic                            i_empty,
    output logic                            o_pop,
    output logic                            o_tvalid,
    input  logic                            i_tready,
    output logic [hcbd_pkg::OUT_DATA_W-1:0] o_tdata,
    output logic                            o_tlast,
    output logic                            o_tuser
);
    import hcbd_pkg::*;

    logic              r_valid, n_valid;
    logic              r_data_done, n_data_done;
    logic              r_kind, n_kind;
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic [LEN_W-1:0]  r_len, n_len;
    logic              r_last, n_last;
    logic              w_load;

    always_comb begin
        w_load      = !r_valid || i_tready;
        o_pop       = 1'b0;
        n_valid     = r_valid && !i_tready;
        n_data_done = r_data_done;
        n_kind      = r_kind;
        n_byte      = r_byte;
        n_len       = r_len;
        n_last      = r_last;
        if (w_load && !i_empty) begin
            n_valid = 1'b1;
            if (i_head.has_data && !r_data_done) begin
                n_kind = KIND_DATA;
                n_byte = i_head.data_byte;
                n_len  = '0;
                n_last = !i_head.has_sum;
                if (i_head.has_sum) begin
                    n_data_done = 1'b1;
                end else begin
                    o_pop = 1'b1;
                end
            end else begin
                n_kind      = KIND_SUMMARY;
                n_byte      = '0;
                n_len       = i_head.length;
                n_last      = 1'b1;
                n_data_done = 1'b0;
                o_pop       = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_data_done <= 1'b0;
        end else begin
            r_valid     <= n_valid;
            r_data_done <= n_data_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_byte <= n_byte;
        r_len  <= n_len;
        r_last <= n_last;
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = {(OUT_DATA_W - LEN_W - BYTE_W)'(0), r_len, r_byte};
    assign o_tlast  = r_last;
    assign o_tuser  = r_kind;

endmodule

// ===== hw/rtl/http_chunked_body_decoder.sv =====
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Decodes an HTTP chunked transfer body one byte per beat.
// ----------------------------------------------------------------------------
// The decoder accepts one body byte per clock cycle and keeps that rate as
// long as the output is taken. Each byte is parsed in the cycle it arrives
// and lands in a four-entry queue; the output register delivers one result
// beat per cycle while it is taken, so a final byte that also carries chunk
// data (two result beats) uses up slack in the queue. A data beat is
// registered in the queue and then in the output register before it appears
// on the output. The input is stalled only when the queue is full.
module http_chunked_body_decoder #(
    parameter int unsigned MAX_BODY_BYTES  = hcbd_pkg::DEF_MAX_BODY_BYTES,
    parameter int unsigned CHUNK_SIZE_BITS = hcbd_pkg::DEF_CHUNK_SIZE_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // tdata: data_byte [7:0]
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [hcbd_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    input  logic                            s_axis_tlast,
    // tdata: decoded_byte [7:0], decoded_length [28:8], zero [31:29]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [hcbd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast,
    // tuser: result_kind [0]
    output logic                            m_axis_tuser
);
    import hcbd_pkg::*;

    logic   w_accept;
    logic   w_push;
    logic   w_pop;
    logic   w_empty;
    logic   w_full;
    t_entry w_entry;
    t_entry w_head;

    assign s_axis_tready = !w_full;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    hcbd_front #(
        .MAX_BODY_BYTES  (MAX_BODY_BYTES),
        .CHUNK_SIZE_BITS (CHUNK_SIZE_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (s_axis_tdata[BYTE_W-1:0]),
        .i_final  (s_axis_tlast),
        .o_push   (w_push),
        .o_entry  (w_entry)
    );

    hcbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    hcbd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast),
        .o_tuser  (m_axis_tuser)
    );

endmodule

// ===== hw/rtl/hcbd_checker.sv =====
// ----------------------------------------------------------------------------
// hcbd_checker
// Port-level checks on the decoder's result stream.
// ----------------------------------------------------------------------------
module hcbd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] i_m_tdata,
    input logic        i_m_tlast,
    input logic        i_m_tuser
);
    import hcbd_pkg::*;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata)
                                      && $stable(i_m_tuser) && $stable(i_m_tlast))
        else $error("Result beat changed while stalled.");

    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (i_m_tuser == KIND_SUMMARY) |-> i_m_tlast)
        else $error("Summary beat without tlast.");

    a_data_no_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (i_m_tuser == KIND_DATA) |-> (i_m_tdata[31:8] == 24'd0))
        else $error("Data beat carries a length.");

    a_summary_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (i_m_tuser == KIND_SUMMARY) |-> (i_m_tdata[7:0] == 8'd0)
                                                     && (i_m_tdata[31:29] == 3'd0))
        else $error("Summary beat carries a data byte.");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tlast  (m_axis_tlast),
    .i_m_tuser  (m_axis_tuser)
);
